FILE: hdl/kds_pkg.sv
// Shared types, constants and sizes for the keyword detection smoother.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package kds_pkg;

	localparam int NUM_KEYWORDS = 8;
	localparam int MAX_WINDOW   = 16;
	localparam int SCORE_WIDTH  = 40;

	// fixed field widths of the beats
	localparam int KW_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int OFFSET_W  = 32;

	localparam int ENT_W  = $clog2(NUM_KEYWORDS + 1);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int HEAD_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LCMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam int SUM_W  = ((SCORE_WIDTH > OFFSET_W) ? SCORE_WIDTH : OFFSET_W) + 1;

	localparam int IN_W        = KW_W + 1 + SCORE_WIDTH;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 13;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	localparam logic signed [OFFSET_W-1:0] RST_THRESHOLD_OFFSET = '0;
	localparam logic [4:0]  RST_WINDOW_LEN     = 5'd3;
	localparam logic [4:0]  RST_MIN_COUNT      = 5'd2;
	localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_OFFSET,
		REG_WINDOW_LEN,
		REG_MIN_COUNT,
		REG_DEBOUNCE_TICKS
	} cfg_reg_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] threshold_offset;
		logic [4:0]  window_len;
		logic [4:0]  min_count;
		logic [15:0] debounce_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT,
		ST_COUNT,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take_item;
		logic close_frame;
		logic walk_step;
		logic decide;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic walk_last;
		logic out_free;
	} status_t;

	// lowest field in the lowest bits
	typedef struct packed {
		logic [4:0]      winner_count;
		logic [KW_W-1:0] frame_keyword;
		logic            frame_hit;
		logic [KW_W-1:0] keyword;
		logic            detected;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/kds_regs.sv
// Configuration register file of the keyword detection smoother.
// Depends on kds_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module kds_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [kds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                  cfg_data,
	output kds_pkg::cfg_t                     cfg
);

	kds_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_offset <= kds_pkg::RST_THRESHOLD_OFFSET;
			cfg_q.window_len       <= kds_pkg::RST_WINDOW_LEN;
			cfg_q.min_count        <= kds_pkg::RST_MIN_COUNT;
			cfg_q.debounce_ticks   <= kds_pkg::RST_DEBOUNCE_TICKS;
		end else if (cfg_valid) begin
			unique case (kds_pkg::cfg_reg_t'(cfg_index))
				kds_pkg::REG_THRESHOLD_OFFSET: cfg_q.threshold_offset <= cfg_data;
				kds_pkg::REG_WINDOW_LEN:       cfg_q.window_len       <= cfg_data[4:0];
				kds_pkg::REG_MIN_COUNT:        cfg_q.min_count        <= cfg_data[4:0];
				kds_pkg::REG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data[15:0];
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/kds_ctrl.sv
// Controller state machine: input acceptance and sequencing of the frame close.
// Depends on kds_pkg for state, command and status types.
`default_nettype none

module kds_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      s_tuser,
	input  wire logic      s_tlast,
	output logic           s_tready,
	input  wire kds_pkg::status_t status,
	output kds_pkg::cmd_t    cmd
);

	kds_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kds_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kds_pkg::ST_IDLE: begin
				// only a score beat that closes a frame leaves idle
				if (s_tvalid && !s_tuser && s_tlast) state_nxt = kds_pkg::ST_HIT;
			end
			kds_pkg::ST_HIT: begin
				state_nxt = status.len_zero ? kds_pkg::ST_DONE : kds_pkg::ST_COUNT;
			end
			kds_pkg::ST_COUNT: begin
				if (status.walk_last) state_nxt = kds_pkg::ST_DECIDE;
			end
			kds_pkg::ST_DECIDE: begin
				state_nxt = kds_pkg::ST_DONE;
			end
			kds_pkg::ST_DONE: begin
				if (status.out_free) state_nxt = kds_pkg::ST_IDLE;
			end
			default: state_nxt = kds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			kds_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.take_item = s_tvalid;
			end
			kds_pkg::ST_HIT:    cmd.close_frame = 1'b1;
			kds_pkg::ST_COUNT:  cmd.walk_step   = 1'b1;
			kds_pkg::ST_DECIDE: cmd.decide      = 1'b1;
			kds_pkg::ST_DONE:   cmd.load_out    = status.out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	a_eof_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser && s_tlast) |=> !s_tready)
		else $error("input still open after an end-of-frame beat");

	a_hit_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kds_pkg::ST_HIT && !status.len_zero) |=>
		(state_q == kds_pkg::ST_COUNT && !s_tready))
		else $error("window walk skipped for a non-empty window");

endmodule

`default_nettype wire

FILE: hdl/kds_dp.sv
// Datapath: frame accumulators, threshold test, hit window, counters and result register.
// Depends on kds_pkg; driven by commands from kds_ctrl.
`default_nettype none

module kds_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire kds_pkg::cfg_t                  cfg,
	input  wire kds_pkg::cmd_t                  cmd,
	output kds_pkg::status_t                    status,
	input  wire logic                           s_tuser,
	input  wire logic [kds_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                           m_tready,
	output logic                                m_tvalid,
	output logic [kds_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	localparam int SW = kds_pkg::SCORE_WIDTH;

	// beat fields
	logic [kds_pkg::KW_W-1:0] item_idx;
	logic                     item_bg;
	logic signed [SW-1:0]     item_score;

	assign item_idx   = s_tdata[kds_pkg::KW_W-1:0];
	assign item_bg    = s_tdata[kds_pkg::KW_W];
	assign item_score = s_tdata[kds_pkg::KW_W+1 +: SW];

	// frame accumulators and tick counter
	logic signed [SW-1:0]     best_q, bg_q;
	logic [kds_pkg::KW_W-1:0] best_kw_q;
	logic                     found_q;
	logic [15:0]              ticks_q;

	// window and walk
	logic [kds_pkg::ENT_W-1:0]  win_q [kds_pkg::MAX_WINDOW];
	logic [kds_pkg::HEAD_W-1:0] head_q, walk_pos_q, head_nxt;
	logic [kds_pkg::CNT_W-1:0]  walk_cnt_q, len;
	logic [kds_pkg::CNT_W-1:0]  cnt_q [kds_pkg::NUM_KEYWORDS];
	logic [kds_pkg::ENT_W-1:0]  ent_rd, ent_wr;

	kds_pkg::result_t pend_q, out_q;
	logic             out_valid_q;

	logic kw_ok, better, hit, det_now, any_found;
	logic signed [kds_pkg::SUM_W-1:0] bg_ext, off_ext, best_ext, sum;
	logic [kds_pkg::KW_W-1:0]  sel_kw;
	logic [kds_pkg::CNT_W-1:0] sel_cnt;
	logic [4:0]                mc, wc_sat;

	assign kw_ok = (5'(item_idx) < 5'(kds_pkg::NUM_KEYWORDS)) && (item_score != kds_pkg::SCORE_MIN);
	assign better = !found_q || (item_score > best_q) ||
		((item_score == best_q) && (item_idx < best_kw_q));

	// exact margin test; a failed background counts as minus infinity
	assign bg_ext   = kds_pkg::SUM_W'(bg_q);
	assign off_ext  = kds_pkg::SUM_W'(cfg.threshold_offset);
	assign best_ext = kds_pkg::SUM_W'(best_q);
	assign sum      = bg_ext + off_ext;
	assign hit      = found_q && ((bg_q == kds_pkg::SCORE_MIN) || (best_ext > sum));

	assign len = (kds_pkg::LCMP_W'(cfg.window_len) > kds_pkg::LCMP_W'(kds_pkg::MAX_WINDOW)) ?
		kds_pkg::CNT_W'(kds_pkg::MAX_WINDOW) : kds_pkg::CNT_W'(cfg.window_len);

	assign head_nxt = (head_q == kds_pkg::HEAD_W'(kds_pkg::MAX_WINDOW - 1)) ?
		'0 : head_q + kds_pkg::HEAD_W'(1);
	assign ent_wr = hit ? (kds_pkg::ENT_W'(best_kw_q) + kds_pkg::ENT_W'(1)) : '0;
	assign ent_rd = win_q[walk_pos_q];

	assign mc = (cfg.min_count == 5'd0) ? 5'd1 : cfg.min_count;

	// lowest keyword at or above the minimum count
	always_comb begin
		any_found = 1'b0;
		sel_kw    = '0;
		sel_cnt   = '0;
		for (int k = kds_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
			if (kds_pkg::LCMP_W'(cnt_q[k]) >= kds_pkg::LCMP_W'(mc)) begin
				any_found = 1'b1;
				sel_kw    = kds_pkg::KW_W'(k);
				sel_cnt   = cnt_q[k];
			end
		end
	end

	assign det_now = any_found && (ticks_q >= cfg.debounce_ticks);
	assign wc_sat  = (kds_pkg::LCMP_W'(sel_cnt) > kds_pkg::LCMP_W'(31)) ? 5'd31 : 5'(sel_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= kds_pkg::SCORE_MIN;
			bg_q      <= kds_pkg::SCORE_MIN;
			best_kw_q <= '0;
			found_q   <= 1'b0;
			ticks_q   <= kds_pkg::TICKS_MAX;
		end else begin
			if (cmd.take_item) begin
				if (s_tuser) begin
					if (ticks_q != kds_pkg::TICKS_MAX) ticks_q <= ticks_q + 16'd1;
				end else if (item_bg) begin
					bg_q <= item_score;
				end else if (kw_ok && better) begin
					best_q    <= item_score;
					best_kw_q <= item_idx;
					found_q   <= 1'b1;
				end
			end
			if (cmd.close_frame) begin
				best_q    <= kds_pkg::SCORE_MIN;
				bg_q      <= kds_pkg::SCORE_MIN;
				best_kw_q <= '0;
				found_q   <= 1'b0;
			end
			if (cmd.decide && det_now) ticks_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kds_pkg::MAX_WINDOW; i++) win_q[i] <= '0;
			head_q <= '0;
		end else if (cmd.close_frame && !status.len_zero) begin
			win_q[head_nxt] <= ent_wr;
			head_q          <= head_nxt;
		end else if (cmd.decide && det_now) begin
			for (int i = 0; i < kds_pkg::MAX_WINDOW; i++) win_q[i] <= '0;
			head_q <= '0;
		end
	end

	// walk back from the newest entry, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_pos_q <= '0;
			walk_cnt_q <= '0;
			for (int k = 0; k < kds_pkg::NUM_KEYWORDS; k++) cnt_q[k] <= '0;
		end else if (cmd.close_frame) begin
			walk_pos_q <= head_nxt;
			walk_cnt_q <= len;
			for (int k = 0; k < kds_pkg::NUM_KEYWORDS; k++) cnt_q[k] <= '0;
		end else if (cmd.walk_step) begin
			for (int k = 0; k < kds_pkg::NUM_KEYWORDS; k++) begin
				if (ent_rd == kds_pkg::ENT_W'(k + 1)) cnt_q[k] <= cnt_q[k] + kds_pkg::CNT_W'(1);
			end
			walk_pos_q <= (walk_pos_q == '0) ?
				kds_pkg::HEAD_W'(kds_pkg::MAX_WINDOW - 1) : walk_pos_q - kds_pkg::HEAD_W'(1);
			walk_cnt_q <= walk_cnt_q - kds_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close_frame) begin
			pend_q.frame_hit     <= hit;
			pend_q.frame_keyword <= found_q ? best_kw_q : '0;
			pend_q.detected      <= 1'b0;
			pend_q.keyword       <= '0;
			pend_q.winner_count  <= '0;
		end else if (cmd.decide) begin
			pend_q.detected     <= det_now;
			pend_q.keyword      <= det_now ? sel_kw : '0;
			pend_q.winner_count <= det_now ? wc_sat : '0;
		end
		if (cmd.load_out) out_q <= pend_q;
	end

	// result register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.len_zero  = (len == '0);
	assign status.walk_last = (walk_cnt_q == kds_pkg::CNT_W'(1));
	assign status.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = kds_pkg::OUT_TDATA_W'(out_q);

	a_det_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && det_now) |=> (head_q == '0 && ticks_q == '0))
		else $error("detection left window head or tick counter set");

	a_det_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.detected) |-> (out_q.winner_count != 5'd0))
		else $error("detection reported with zero window count");

endmodule

`default_nettype wire

FILE: hdl/keyword_detection_smoother.sv
// Top level of the keyword detection smoother: register file, controller and datapath.
// Depends on kds_pkg, kds_regs, kds_ctrl and kds_dp.
//
//  channel | direction | beat contents
//  s_*     | in        | tdata: model_index, is_background, score; tuser: mode; tlast: end_of_frame
//  m_*     | out       | tdata: detected, keyword, frame_hit, frame_keyword, winner_count
//  cfg_*   | in        | cfg_index selects the register, cfg_data carries the value
//
// A tick or a score beat that does not close a frame is taken in idle with input kept open.
// A frame-closing beat runs the hit, count, decide and done states (hit to done with a zero
// window length): the window walk reads one entry a cycle from the window register file.
// While the close runs input is held off; a waiting result beat is held in the
// output register and stalls the next close only when it is still untaken.
// Reset clears the window and all control state and sets the tick counter to saturation.
`default_nettype none

module keyword_detection_smoother (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// model_index [2:0], is_background [3], score [43:4], zero fill above
	input  wire logic [kds_pkg::IN_TDATA_W-1:0]    s_tdata,
	// mode [0]
	input  wire logic                             s_tuser,
	input  wire logic                             s_tlast,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// detected [0], keyword [3:1], frame_hit [4], frame_keyword [7:5],
	// winner_count [12:8], zero fill above
	output logic [kds_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [kds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                      cfg_data
);

	kds_pkg::cfg_t    cfg;
	kds_pkg::cmd_t    cmd;
	kds_pkg::status_t status;

	kds_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	kds_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
